// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion that is disabled during reset.
`define WFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define WFA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hdl/wfa_pkg.sv =====
// Types and constants for the worst-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package wfa_pkg;
  localparam int unsigned DATA_W         = 16;
  localparam int unsigned SIZE_W         = 17;
  localparam int unsigned MAX_BLOCKS_DEF = 16;
  localparam logic [DATA_W-1:0] POOL_RESET = 16'd1024;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN,
    S_A_DEC,
    S_F_BUSY,
    S_F_POS,
    S_F_DEC,
    S_SHR,
    S_SHI,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic              cnt_inc;
    logic              cnt_dec;
    logic [DATA_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } ftbl_ctl_t;

  typedef struct packed {
    logic              we;
    logic              clr;
    logic [DATA_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } btbl_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/wfa_free_tbl.sv =====
// Address-ordered free table with entry count.
`timescale 1ns / 1ps
`default_nettype none
module wfa_free_tbl #(
  parameter int unsigned MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS),
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          init,
  input  wire logic [wfa_pkg::DATA_W-1:0]    init_size,
  input  wire logic [IDX_W-1:0]              rd_idx,
  output logic      [wfa_pkg::DATA_W-1:0]    rd_start,
  output logic      [wfa_pkg::SIZE_W-1:0]    rd_size,
  input  wire logic [IDX_W-1:0]              wr_idx,
  input  wire wfa_pkg::ftbl_ctl_t            ctl,
  output logic      [CNT_W-1:0]              cnt
);
  logic [wfa_pkg::DATA_W-1:0] start_r [MAX_BLOCKS];
  logic [wfa_pkg::SIZE_W-1:0] size_r  [MAX_BLOCKS];
  logic [CNT_W-1:0]           cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= CNT_W'(1);
      start_r[0] <= '0;
      size_r[0]  <= {1'b0, wfa_pkg::POOL_RESET};
    end else if (init) begin
      cnt_r      <= (init_size != '0) ? CNT_W'(1) : '0;
      start_r[0] <= '0;
      size_r[0]  <= {1'b0, init_size};
    end else begin
      if (ctl.we) begin
        start_r[wr_idx] <= ctl.start;
        size_r[wr_idx]  <= ctl.size;
      end
      if (ctl.cnt_inc) cnt_r <= cnt_r + CNT_W'(1);
      else if (ctl.cnt_dec) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign rd_start = start_r[rd_idx];
  assign rd_size  = size_r[rd_idx];
  assign cnt      = cnt_r;
endmodule
`default_nettype wire

// ===== hdl/wfa_busy_tbl.sv =====
// Busy table with valid bits and first-free-slot encoder.
`timescale 1ns / 1ps
`default_nettype none
module wfa_busy_tbl #(
  parameter int unsigned MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          init,
  input  wire logic [IDX_W-1:0]              rd_idx,
  output logic                               rd_valid,
  output logic      [wfa_pkg::DATA_W-1:0]    rd_start,
  output logic      [wfa_pkg::SIZE_W-1:0]    rd_size,
  input  wire logic [IDX_W-1:0]              wr_idx,
  input  wire wfa_pkg::btbl_ctl_t            ctl,
  output logic      [IDX_W-1:0]              slot,
  output logic                               full
);
  logic [MAX_BLOCKS-1:0]      valid_r;
  logic [wfa_pkg::DATA_W-1:0] start_r [MAX_BLOCKS];
  logic [wfa_pkg::SIZE_W-1:0] size_r  [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      valid_r <= '0;
    end else if (ctl.we) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (ctl.clr) begin
      valid_r[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      start_r[wr_idx] <= ctl.start;
      size_r[wr_idx]  <= ctl.size;
    end
  end

  always_comb begin
    slot = '0;
    full = 1'b1;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        slot = IDX_W'(i);
        full = 1'b0;
      end
    end
  end

  assign rd_valid = valid_r[rd_idx];
  assign rd_start = start_r[rd_idx];
  assign rd_size  = size_r[rd_idx];
endmodule
`default_nettype wire

// ===== hdl/wfa_ctrl.sv =====
// Sequencer and shared compare/add datapath for the allocator.
`timescale 1ns / 1ps
`default_nettype none
module wfa_ctrl #(
  parameter int unsigned MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS),
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_mode,
  input  wire logic [wfa_pkg::DATA_W-1:0]    in_request_size,
  input  wire logic [wfa_pkg::DATA_W-1:0]    in_start_address,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [1:0]                    out_status,
  output logic      [wfa_pkg::DATA_W-1:0]    out_address,
  output logic                               idle,
  output logic      [IDX_W-1:0]              f_rd_idx,
  input  wire logic [wfa_pkg::DATA_W-1:0]    f_rd_start,
  input  wire logic [wfa_pkg::SIZE_W-1:0]    f_rd_size,
  output logic      [IDX_W-1:0]              f_wr_idx,
  output wfa_pkg::ftbl_ctl_t                 f_ctl,
  input  wire logic [CNT_W-1:0]              f_cnt,
  output logic      [IDX_W-1:0]              b_idx,
  input  wire logic                          b_rd_valid,
  input  wire logic [wfa_pkg::DATA_W-1:0]    b_rd_start,
  input  wire logic [wfa_pkg::SIZE_W-1:0]    b_rd_size,
  output wfa_pkg::btbl_ctl_t                 b_ctl,
  input  wire logic [IDX_W-1:0]              b_slot,
  input  wire logic                          b_full
);
  localparam int unsigned DW = wfa_pkg::DATA_W;
  localparam int unsigned SW = wfa_pkg::SIZE_W;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_BLOCKS);

  wfa_pkg::state_t state_r, state_nxt;

  logic                mode_r;
  logic [DW-1:0]       size_r, start_r;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [IDX_W-1:0]    best_r, best_nxt, hit_r, hit_nxt;
  logic                found_r, found_nxt;
  logic [SW-1:0]       best_size_r, best_size_nxt;
  logic [DW-1:0]       best_start_r, best_start_nxt;
  logic [DW-1:0]       prev_start_r, prev_start_nxt, next_start_r, next_start_nxt;
  logic [SW:0]         prev_end_r, prev_end_nxt;
  logic [SW-1:0]       prev_size_r, prev_size_nxt, next_size_r, next_size_nxt;
  wfa_pkg::status_t    status_r, status_nxt;
  logic [DW-1:0]       addr_r, addr_nxt;
  logic                out_valid_r;
  wfa_pkg::status_t    out_status_r;
  logic [DW-1:0]       out_addr_r;

  logic          accept, scan_more, fits, ge_best, bmatch, pos_le, jp, jn, load_out;
  logic [SW-1:0] req_z, rem, end_a;
  logic [CNT_W-1:0] i_inc, i_dec;

  assign accept    = in_valid && (state_r == wfa_pkg::S_IDLE);
  assign in_stall  = (state_r != wfa_pkg::S_IDLE);
  assign idle      = (state_r == wfa_pkg::S_IDLE);
  assign load_out  = (state_r == wfa_pkg::S_DONE) && (!out_valid_r || !out_stall);
  assign i_inc     = i_r + CNT_W'(1);
  assign i_dec     = i_r - CNT_W'(1);
  assign req_z     = {1'b0, size_r};
  assign scan_more = (i_r < f_cnt);
  assign fits      = (f_rd_size >= req_z);
  assign ge_best   = (f_rd_size >= best_size_r);
  assign bmatch    = b_rd_valid && (b_rd_start == start_r) && (b_rd_size == req_z);
  assign pos_le    = (f_rd_start <= start_r);
  assign rem       = best_size_r - req_z;
  assign end_a     = {1'b0, start_r} + req_z;
  assign jp        = (pos_r != '0) && (prev_end_r == {2'b00, start_r});
  assign jn        = (pos_r < f_cnt) && (end_a == {1'b0, next_start_r});

  always_comb begin
    unique case (state_r)
      wfa_pkg::S_SHR: f_rd_idx = i_inc[IDX_W-1:0];
      wfa_pkg::S_SHI: f_rd_idx = i_dec[IDX_W-1:0];
      default:        f_rd_idx = i_r[IDX_W-1:0];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wfa_pkg::S_IDLE: begin
        if (accept) begin
          if (in_request_size == '0) state_nxt = wfa_pkg::S_DONE;
          else if (in_mode == wfa_pkg::MODE_ALLOC) state_nxt = wfa_pkg::S_A_SCAN;
          else state_nxt = wfa_pkg::S_F_BUSY;
        end
      end
      wfa_pkg::S_A_SCAN: if (!scan_more) state_nxt = wfa_pkg::S_A_DEC;
      wfa_pkg::S_A_DEC: begin
        if (!found_r || b_full || rem != '0) state_nxt = wfa_pkg::S_DONE;
        else state_nxt = wfa_pkg::S_SHR;
      end
      wfa_pkg::S_F_BUSY: begin
        if (i_r >= MAXC) state_nxt = wfa_pkg::S_DONE;
        else if (bmatch) state_nxt = wfa_pkg::S_F_POS;
      end
      wfa_pkg::S_F_POS: if (!(scan_more && pos_le)) state_nxt = wfa_pkg::S_F_DEC;
      wfa_pkg::S_F_DEC: begin
        if (!jp && !jn) state_nxt = (f_cnt >= MAXC) ? wfa_pkg::S_DONE : wfa_pkg::S_SHI;
        else if (jp && jn) state_nxt = wfa_pkg::S_SHR;
        else state_nxt = wfa_pkg::S_DONE;
      end
      wfa_pkg::S_SHR: if (i_inc >= f_cnt) state_nxt = wfa_pkg::S_DONE;
      wfa_pkg::S_SHI: if (i_r <= pos_r) state_nxt = wfa_pkg::S_DONE;
      wfa_pkg::S_DONE: if (load_out) state_nxt = wfa_pkg::S_IDLE;
      default: state_nxt = wfa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    i_nxt          = i_r;
    pos_nxt        = pos_r;
    best_nxt       = best_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    best_size_nxt  = best_size_r;
    best_start_nxt = best_start_r;
    prev_start_nxt = prev_start_r;
    prev_end_nxt   = prev_end_r;
    prev_size_nxt  = prev_size_r;
    next_start_nxt = next_start_r;
    next_size_nxt  = next_size_r;
    status_nxt     = status_r;
    addr_nxt       = addr_r;
    f_wr_idx       = i_r[IDX_W-1:0];
    f_ctl          = '0;
    b_idx          = i_r[IDX_W-1:0];
    b_ctl          = '0;
    unique case (state_r)
      wfa_pkg::S_IDLE: begin
        i_nxt         = '0;
        found_nxt     = 1'b0;
        best_size_nxt = '0;
        addr_nxt      = '0;
        status_nxt    = wfa_pkg::ST_OK;
        if (in_request_size == '0) begin
          status_nxt = (in_mode == wfa_pkg::MODE_ALLOC) ? wfa_pkg::ST_NOFIT
                                                        : wfa_pkg::ST_NOMATCH;
        end
      end
      wfa_pkg::S_A_SCAN: begin
        if (scan_more) begin
          if (fits && ge_best) begin
            found_nxt      = 1'b1;
            best_nxt       = i_r[IDX_W-1:0];
            best_size_nxt  = f_rd_size;
            best_start_nxt = f_rd_start;
          end
          i_nxt = i_inc;
        end
      end
      wfa_pkg::S_A_DEC: begin
        b_idx = b_slot;
        if (!found_r) begin
          status_nxt = wfa_pkg::ST_NOFIT;
        end else if (b_full) begin
          status_nxt = wfa_pkg::ST_FULL;
        end else begin
          addr_nxt    = best_start_r;
          b_ctl.we    = 1'b1;
          b_ctl.start = best_start_r;
          b_ctl.size  = req_z;
          f_wr_idx    = best_r;
          i_nxt       = {{(CNT_W-IDX_W){1'b0}}, best_r};
          if (rem != '0) begin
            f_ctl.we    = 1'b1;
            f_ctl.start = best_start_r + size_r;
            f_ctl.size  = rem;
          end
        end
      end
      wfa_pkg::S_F_BUSY: begin
        if (i_r >= MAXC) begin
          status_nxt = wfa_pkg::ST_NOMATCH;
        end else if (bmatch) begin
          hit_nxt = i_r[IDX_W-1:0];
          i_nxt   = '0;
        end else begin
          i_nxt = i_inc;
        end
      end
      wfa_pkg::S_F_POS: begin
        if (scan_more && pos_le) begin
          prev_start_nxt = f_rd_start;
          prev_size_nxt  = f_rd_size;
          prev_end_nxt   = {1'b0, f_rd_start} + {1'b0, f_rd_size};
          i_nxt          = i_inc;
        end else begin
          next_start_nxt = f_rd_start;
          next_size_nxt  = f_rd_size;
          pos_nxt        = i_r;
        end
      end
      wfa_pkg::S_F_DEC: begin
        b_idx = hit_r;
        if (!jp && !jn && f_cnt >= MAXC) begin
          status_nxt = wfa_pkg::ST_FULL;
        end else begin
          b_ctl.clr = 1'b1;
          if (jp) begin
            f_wr_idx    = pos_r[IDX_W-1:0] - IDX_W'(1);
            f_ctl.we    = 1'b1;
            f_ctl.start = prev_start_r;
            f_ctl.size  = jn ? prev_size_r + req_z + next_size_r : prev_size_r + req_z;
            i_nxt       = pos_r;
          end else if (jn) begin
            f_wr_idx    = pos_r[IDX_W-1:0];
            f_ctl.we    = 1'b1;
            f_ctl.start = start_r;
            f_ctl.size  = next_size_r + req_z;
          end else begin
            i_nxt = f_cnt;
          end
        end
      end
      wfa_pkg::S_SHR: begin
        if (i_inc < f_cnt) begin
          f_ctl.we    = 1'b1;
          f_ctl.start = f_rd_start;
          f_ctl.size  = f_rd_size;
          i_nxt       = i_inc;
        end else begin
          f_ctl.cnt_dec = 1'b1;
        end
      end
      wfa_pkg::S_SHI: begin
        f_ctl.we = 1'b1;
        if (i_r > pos_r) begin
          f_ctl.start = f_rd_start;
          f_ctl.size  = f_rd_size;
          i_nxt       = i_dec;
        end else begin
          f_ctl.start   = start_r;
          f_ctl.size    = req_z;
          f_ctl.cnt_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wfa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      size_r  <= in_request_size;
      start_r <= in_start_address;
    end
    if (load_out) begin
      out_status_r <= status_r;
      out_addr_r   <= (status_r == wfa_pkg::ST_OK && mode_r == wfa_pkg::MODE_ALLOC)
                      ? addr_r : '0;
    end
    i_r          <= i_nxt;
    pos_r        <= pos_nxt;
    best_r       <= best_nxt;
    hit_r        <= hit_nxt;
    found_r      <= found_nxt;
    best_size_r  <= best_size_nxt;
    best_start_r <= best_start_nxt;
    prev_start_r <= prev_start_nxt;
    prev_end_r   <= prev_end_nxt;
    prev_size_r  <= prev_size_nxt;
    next_start_r <= next_start_nxt;
    next_size_r  <= next_size_nxt;
    status_r     <= status_nxt;
    addr_r       <= addr_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_address = out_addr_r;
endmodule
`default_nettype wire

// ===== hdl/worst_fit_allocator_coalescing.sv =====
// Top level of the worst-fit allocator with coalescing.
// Allocate scans the free entries, then may shift free entries; free scans the busy
// table, then the free table for the insert position, then may shift free entries.
// One transaction at a time; in_stall is high while working.
// The table scans and shifts handle one entry per cycle.
// Reset: pool 1024 as one free block, busy table empty; a cfg write sets a pool of cfg_data (none if zero).
`timescale 1ns / 1ps
`default_nettype none
module worst_fit_allocator_coalescing #(
  parameter int unsigned MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_mode,
  input  wire logic [wfa_pkg::DATA_W-1:0]  in_request_size,
  input  wire logic [wfa_pkg::DATA_W-1:0]  in_start_address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [1:0]                  out_status,
  output logic      [wfa_pkg::DATA_W-1:0]  out_address,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [wfa_pkg::DATA_W-1:0]  cfg_data
);
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  logic                       idle, init;
  logic [IDX_W-1:0]           f_rd_idx, f_wr_idx, b_idx, b_slot;
  logic [wfa_pkg::DATA_W-1:0] f_rd_start, b_rd_start;
  logic [wfa_pkg::SIZE_W-1:0] f_rd_size, b_rd_size;
  logic [CNT_W-1:0]           f_cnt;
  logic                       b_rd_valid, b_full;
  wfa_pkg::ftbl_ctl_t         f_ctl;
  wfa_pkg::btbl_ctl_t         b_ctl;

  assign cfg_ready = idle && !in_valid;
  assign init      = cfg_valid && cfg_ready;

  wfa_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_request_size,
    .in_start_address, .out_valid, .out_stall, .out_status, .out_address,
    .idle, .f_rd_idx, .f_rd_start, .f_rd_size, .f_wr_idx, .f_ctl, .f_cnt,
    .b_idx, .b_rd_valid, .b_rd_start, .b_rd_size, .b_ctl, .b_slot, .b_full
  );

  wfa_free_tbl #(.MAX_BLOCKS(MAX_BLOCKS)) u_free (
    .clk, .rst_n, .init, .init_size(cfg_data), .rd_idx(f_rd_idx),
    .rd_start(f_rd_start), .rd_size(f_rd_size), .wr_idx(f_wr_idx),
    .ctl(f_ctl), .cnt(f_cnt)
  );

  wfa_busy_tbl #(.MAX_BLOCKS(MAX_BLOCKS)) u_busy (
    .clk, .rst_n, .init, .rd_idx(b_idx), .rd_valid(b_rd_valid),
    .rd_start(b_rd_start), .rd_size(b_rd_size), .wr_idx(b_idx),
    .ctl(b_ctl), .slot(b_slot), .full(b_full)
  );
endmodule
`default_nettype wire

// ===== hdl/wfa_checker.sv =====
// Port-level checker for the allocator and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module wfa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_address,
  input wire logic        cfg_ready
);
  `WFA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_address), "result dropped while stalled")
  `WFA_ASSERT(a_err_addr, out_valid && out_status != wfa_pkg::ST_OK |-> out_address == '0, "nonzero address on error")
  `WFA_ASSERT(a_busy_after, in_valid && !in_stall |=> in_stall && !cfg_ready, "not busy after accept")
  `WFA_ASSERT_ALWAYS(a_cfg_idle, cfg_ready |-> !in_stall, "config ready while busy")
endmodule

bind worst_fit_allocator_coalescing wfa_checker u_wfa_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_status,
  .out_address, .cfg_ready
);
`default_nettype wire
